@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define LTI_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// condition must never be seen outside reset
`define LTI_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define LTI_ASSERT(lbl, clk, rst_n, prop)
`define LTI_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/ltint_pkg.sv @@
// ----------------------------------------------------------------------------
// ltint_pkg
// Types, codes and constants of the Lagrange table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package ltint_pkg;
	localparam int TABLE_DEPTH_DEF = 2048;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 12;
	localparam int DIV_STEPS       = 58;
	localparam int DIV_DVD_W       = 58;
	localparam int DIV_DEN_W       = 33;

	localparam logic [CFG_INDEX_W-1:0] REG_INTERP_ORDER   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_IN_USE = 2'd1;

	localparam logic CMD_QUERY = 1'b0;
	localparam logic CMD_LOAD  = 1'b1;

	localparam logic [1:0] STAT_INSIDE = 2'd0;
	localparam logic [1:0] STAT_ABOVE  = 2'd1;
	localparam logic [1:0] STAT_BELOW  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RLAST,
		S_CLAST,
		S_SREAD,
		S_SCHK,
		S_STEN,
		S_NREAD,
		S_NSTORE,
		S_DIST,
		S_FSEL,
		S_DIV,
		S_WMUL,
		S_WRND,
		S_VMUL,
		S_VACC,
		S_FIN
	} lti_state_t;

	// separate state for holding the result
	typedef enum logic {
		O_EMPTY,
		O_FULL
	} lti_out_t;
endpackage
`default_nettype wire

@@ hdl/ltint_if.sv @@
// ----------------------------------------------------------------------------
// ltint_if
// Channel interfaces: request items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface ltint_req_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [10:0]        entry_index;
	logic signed [31:0] log_key;
	logic [31:0]        entry_value;
	modport source (output valid, command, entry_index, log_key, entry_value, input ready);
	modport sink (input valid, command, entry_index, log_key, entry_value, output ready);
endinterface

interface ltint_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] distance;
	logic [1:0]  status;
	modport source (output valid, distance, status, input ready);
	modport sink (input valid, distance, status, output ready);
endinterface

interface ltint_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [ltint_pkg::CFG_INDEX_W-1:0]    index;
	logic [ltint_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/ltint_tables.sv @@
// ----------------------------------------------------------------------------
// ltint_tables
// Key and value memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ltint_tables #(
	parameter int DEPTH = ltint_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire logic signed [31:0]   wr_key,
	input  wire logic [31:0]          wr_value,
	input  wire logic [AW-1:0]        rd_addr,
	output logic signed [31:0]        rd_key,
	output logic [31:0]               rd_value
);
	logic signed [31:0] key_mem [DEPTH];
	logic [31:0]        val_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_value;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_key   <= key_mem[rd_addr];
		rd_value <= val_mem[rd_addr];
	end
endmodule
`default_nettype wire

@@ hdl/ltint_div.sv @@
// ----------------------------------------------------------------------------
// ltint_div
// Restoring divider, one quotient bit per cycle; magnitude saturated to 31 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module ltint_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [ltint_pkg::DIV_DVD_W-1:0]     dividend,
	input  wire logic [ltint_pkg::DIV_DEN_W-1:0]     divisor,
	output logic                                     busy,
	output logic                                     done,
	output logic [30:0]                              quot_mag
);
	localparam int CNT_W = $clog2(ltint_pkg::DIV_STEPS);
	localparam int DW = ltint_pkg::DIV_DVD_W;
	localparam int NW = ltint_pkg::DIV_DEN_W;

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    dq_q;
	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    den_q;
	logic [NW:0]      rem_sh;
	logic [NW:0]      diff;

	// one trial subtraction per cycle
	always_comb begin
		rem_sh = {rem_q, dq_q[DW-1]};
		diff   = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(ltint_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath; quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= diff[NW-1:0];
				dq_q  <= {dq_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[NW-1:0];
				dq_q  <= {dq_q[DW-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quot_mag = (|dq_q[DW-1:31]) ? '1 : dq_q[30:0];
endmodule
`default_nettype wire

@@ hdl/lagrange_table_interpolator.sv @@
// ----------------------------------------------------------------------------
// lagrange_table_interpolator
// Table lookup with Lagrange interpolation of order 1 to 3 in fixed point.
// ----------------------------------------------------------------------------
//  channel  dir  beat carries
//  req      in   command, entry_index, log_key (Q8.24), entry_value (Q16.16)
//  rsp      out  distance (Q16.16), status
//  cfg      in   index, data (interp_order, entries_in_use)
//
//  A load is written into the tables as it is accepted. A query reads the last
//  key, scans the keys linearly up to the interval i, loads m+1 stencil nodes
//  (a read and a store state each) and, unless two nodes share a key, computes
//  m*(m+1) factors, each a select state plus a run of the serial divider, with
//  a multiply and a rounding state per product and a multiply and an accumulate
//  state per weighted value. A key at or past the last entry skips the scan.
//  The result has its own register; a finished query waits in its last state
//  while the previous result is still held on rsp, and req stalls meanwhile.
//  Reset sets interp_order to 1 and entries_in_use to 2; tables are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lagrange_table_interpolator #(
	parameter int TABLE_DEPTH = ltint_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ltint_req_if.sink   req,
	ltint_rsp_if.source rsp,
	ltint_cfg_if.sink   cfg
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	ltint_pkg::lti_state_t state_q, state_d;

	logic [1:0]         order_q;
	logic [11:0]        entries_q;
	logic signed [31:0] x_q;
	logic [CW-1:0]      n_q;
	logic [AW-1:0]      j_q, i_q, start_q;
	logic               below_q;
	logic [1:0]         m_q, t_q, k_q, jj_q;
	logic signed [31:0] nk_q [4];
	logic [31:0]        nv_q [4];
	logic               first_q, fneg_q, wneg_q;
	logic signed [31:0] w_q, f_q;
	logic signed [67:0] acc_q;
	logic [31:0]        dist_q;
	logic [1:0]         status_q;
	logic signed [65:0] prod_q;
	logic [31:0]        rsp_dist_q;
	logic [1:0]         rsp_status_q;

	logic [AW-1:0]      rd_addr;
	logic signed [31:0] rd_key;
	logic [31:0]        rd_value;
	logic               wr_en;
	logic [31:0]        idx_ext;
	logic               req_acc;
	logic               rsp_stall;

	logic [31:0]        n_calc, ent32, i32, n32;
	logic [1:0]         m0, m1, m2;
	logic [AW-1:0]      start_calc;
	logic               dup;
	logic               sel_hi;

	logic signed [32:0] num, den;
	logic [32:0]        un, ud;
	logic [57:0]        dividend;
	logic               div_start, div_busy, div_done;
	logic [30:0]        div_mag;
	logic signed [31:0] f_val;

	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic [30:0]        wm, fm;
	logic [62:0]        rsum;
	logic [30:0]        wr_mag;
	logic signed [67:0] fin;
	logic [31:0]        fin_sat;
	logic [31:0]        fin_dist;

	assign req_acc = req.valid && req.ready;
	assign idx_ext = 32'(req.entry_index);
	assign wr_en   = req_acc && (req.command == ltint_pkg::CMD_LOAD)
		&& (idx_ext < 32'(TABLE_DEPTH));

	ltint_tables #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_tables (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (idx_ext[AW-1:0]),
		.wr_key   (req.log_key),
		.wr_value (req.entry_value),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	ltint_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (ud),
		.busy     (div_busy),
		.done     (div_done),
		.quot_mag (div_mag)
	);

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q   <= 2'd1;
			entries_q <= 12'd2;
		end else if (cfg.valid) begin
			case (cfg.index)
				ltint_pkg::REG_INTERP_ORDER:   order_q   <= cfg.data[1:0];
				ltint_pkg::REG_ENTRIES_IN_USE: entries_q <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	// entry count clamp and stencil selection
	always_comb begin
		ent32 = 32'(entries_q);
		if (ent32 < 32'd2)
			n_calc = 32'd2;
		else if (ent32 > 32'(TABLE_DEPTH))
			n_calc = 32'(TABLE_DEPTH);
		else
			n_calc = ent32;
		i32 = 32'(i_q);
		n32 = 32'(n_q);
		m0  = (order_q == 2'd0) ? 2'd1 : order_q;
		m1  = (m0 == 2'd3 && i32 + 32'd2 >= n32) ? 2'd2 : m0;
		m2  = (32'(m1) > n32 - 32'd1) ? 2'(n32 - 32'd1) : m1;
		start_calc = (m2 == 2'd1 || i_q == '0) ? i_q : i_q - 1'b1;
	end

	// repeated keys in the stencil
	always_comb begin
		dup = 1'b0;
		for (int a = 0; a < 4; a++)
			for (int b = a + 1; b < 4; b++)
				if (2'(b) <= m_q && nk_q[a] == nk_q[b])
					dup = 1'b1;
		sel_hi = (i_q != start_q);
	end

	// factor operands: (x - key[j]) / (key[k] - key[j]) in Q8.24
	always_comb begin
		num = 33'(x_q) - 33'(nk_q[jj_q]);
		den = 33'(nk_q[k_q]) - 33'(nk_q[jj_q]);
		un  = num[32] ? 33'(-num) : 33'(num);
		ud  = den[32] ? 33'(-den) : 33'(den);
		dividend = {1'b0, un, 24'd0} + 58'(ud >> 1);
		f_val = fneg_q ? -$signed({1'b0, div_mag}) : $signed({1'b0, div_mag});
	end

	// shared multiplier operands
	always_comb begin
		wm = w_q[31] ? 31'(-w_q) : w_q[30:0];
		fm = f_q[31] ? 31'(-f_q) : f_q[30:0];
		if (state_q == ltint_pkg::S_VMUL) begin
			mul_a = $signed({2'b00, nv_q[k_q]});
			mul_b = w_q;
		end else begin
			mul_a = $signed(34'(wm));
			mul_b = $signed({1'b0, fm});
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// rounding of products and of the final sum
	always_comb begin
		rsum    = prod_q[62:0] + 63'd8388608;
		wr_mag  = (|rsum[62:55]) ? '1 : rsum[54:24];
		fin     = acc_q + 68'sd8388608;
		if (fin[67])
			fin_sat = '0;
		else if (|fin[66:56])
			fin_sat = '1;
		else
			fin_sat = fin[55:24];
		fin_dist = (status_q != ltint_pkg::STAT_ABOVE && !dup) ? fin_sat : dist_q;
	end

	// sequencer next state
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		div_start = 1'b0;
		rd_addr   = j_q;
		case (state_q)
			ltint_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && req.command == ltint_pkg::CMD_QUERY)
					state_d = ltint_pkg::S_RLAST;
			end
			ltint_pkg::S_RLAST: begin
				rd_addr = AW'(n_q - 1'b1);
				state_d = ltint_pkg::S_CLAST;
			end
			ltint_pkg::S_CLAST: begin
				state_d = (x_q >= rd_key) ? ltint_pkg::S_FIN : ltint_pkg::S_SREAD;
			end
			ltint_pkg::S_SREAD: begin
				state_d = ltint_pkg::S_SCHK;
			end
			ltint_pkg::S_SCHK: begin
				if (j_q == '0)
					state_d = (n_q == CW'(2)) ? ltint_pkg::S_STEN : ltint_pkg::S_SREAD;
				else if (x_q < rd_key || CW'(j_q) == CW'(n_q - CW'(2)))
					state_d = ltint_pkg::S_STEN;
				else
					state_d = ltint_pkg::S_SREAD;
			end
			ltint_pkg::S_STEN: begin
				state_d = ltint_pkg::S_NREAD;
			end
			ltint_pkg::S_NREAD: begin
				rd_addr = start_q + AW'(t_q);
				state_d = ltint_pkg::S_NSTORE;
			end
			ltint_pkg::S_NSTORE: begin
				state_d = (t_q == m_q) ? ltint_pkg::S_DIST : ltint_pkg::S_NREAD;
			end
			ltint_pkg::S_DIST: begin
				state_d = dup ? ltint_pkg::S_FIN : ltint_pkg::S_FSEL;
			end
			ltint_pkg::S_FSEL: begin
				if (jj_q == k_q) begin
					if (jj_q == m_q)
						state_d = ltint_pkg::S_VMUL;
				end else begin
					div_start = 1'b1;
					state_d   = ltint_pkg::S_DIV;
				end
			end
			ltint_pkg::S_DIV: begin
				if (div_done) begin
					if (!first_q)
						state_d = ltint_pkg::S_WMUL;
					else if (jj_q == m_q)
						state_d = ltint_pkg::S_VMUL;
					else
						state_d = ltint_pkg::S_FSEL;
				end
			end
			ltint_pkg::S_WMUL: begin
				state_d = ltint_pkg::S_WRND;
			end
			ltint_pkg::S_WRND: begin
				state_d = (jj_q == m_q) ? ltint_pkg::S_VMUL : ltint_pkg::S_FSEL;
			end
			ltint_pkg::S_VMUL: begin
				state_d = ltint_pkg::S_VACC;
			end
			ltint_pkg::S_VACC: begin
				state_d = (k_q == m_q) ? ltint_pkg::S_FIN : ltint_pkg::S_FSEL;
			end
			ltint_pkg::S_FIN: begin
				if (!rsp.valid)
					state_d = ltint_pkg::S_IDLE;
			end
			default: state_d = ltint_pkg::S_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ltint_pkg::S_IDLE;
			rsp.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp.valid && rsp.ready)
				rsp.valid <= 1'b0;
			else if (state_q == ltint_pkg::S_FIN)
				rsp.valid <= 1'b1;
		end
	end

	// result register, loaded once the previous beat has left
	always_ff @(posedge clk) begin
		if (state_q == ltint_pkg::S_FIN && !rsp.valid) begin
			rsp_dist_q   <= fin_dist;
			rsp_status_q <= status_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ltint_pkg::S_IDLE: begin
				x_q <= req.log_key;
				n_q <= CW'(n_calc);
			end
			ltint_pkg::S_CLAST: begin
				j_q <= '0;
				if (x_q >= rd_key) begin
					dist_q   <= rd_value;
					status_q <= ltint_pkg::STAT_ABOVE;
				end
			end
			ltint_pkg::S_SCHK: begin
				if (j_q == '0) begin
					below_q <= (x_q < rd_key);
					i_q     <= '0;
					j_q     <= AW'(1);
				end else if (x_q < rd_key) begin
					i_q <= j_q - 1'b1;
				end else begin
					i_q <= j_q;
					j_q <= j_q + 1'b1;
				end
			end
			ltint_pkg::S_STEN: begin
				m_q      <= m2;
				start_q  <= start_calc;
				t_q      <= 2'd0;
				status_q <= below_q ? ltint_pkg::STAT_BELOW : ltint_pkg::STAT_INSIDE;
			end
			ltint_pkg::S_NSTORE: begin
				nk_q[t_q] <= rd_key;
				nv_q[t_q] <= rd_value;
				t_q       <= t_q + 1'b1;
			end
			ltint_pkg::S_DIST: begin
				dist_q  <= sel_hi ? nv_q[1] : nv_q[0];
				acc_q   <= '0;
				k_q     <= 2'd0;
				jj_q    <= 2'd0;
				first_q <= 1'b1;
			end
			ltint_pkg::S_FSEL: begin
				if (jj_q == k_q) begin
					if (jj_q != m_q)
						jj_q <= jj_q + 1'b1;
				end else begin
					fneg_q <= num[32] ^ den[32];
				end
			end
			ltint_pkg::S_DIV: begin
				if (div_done) begin
					f_q <= f_val;
					if (first_q) begin
						w_q     <= f_val;
						first_q <= 1'b0;
						if (jj_q != m_q)
							jj_q <= jj_q + 1'b1;
					end
				end
			end
			ltint_pkg::S_WMUL: begin
				wneg_q <= w_q[31] ^ f_q[31];
			end
			ltint_pkg::S_WRND: begin
				w_q <= wneg_q ? -$signed({1'b0, wr_mag}) : $signed({1'b0, wr_mag});
				if (jj_q != m_q)
					jj_q <= jj_q + 1'b1;
			end
			ltint_pkg::S_VACC: begin
				acc_q   <= acc_q + 68'(prod_q);
				k_q     <= k_q + 1'b1;
				jj_q    <= 2'd0;
				first_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign rsp.distance = rsp_dist_q;
	assign rsp.status   = rsp_status_q;
	assign rsp_stall    = rsp.valid && !rsp.ready;

	// checks
	`LTI_ASSERT(a_result_holds, clk, arst_n, rsp_stall |=> (rsp.valid && $stable({rsp.distance, rsp.status})))
	`LTI_ASSERT(a_query_goes_busy, clk, arst_n, (req_acc && req.command == ltint_pkg::CMD_QUERY) |=> !req.ready)
	`LTI_NEVER(a_div_outside_div, clk, arst_n, div_busy && state_q != ltint_pkg::S_DIV)
endmodule
`default_nettype wire

@@ tb/ltint_checker.sv @@
// ----------------------------------------------------------------------------
// ltint_checker
// Watches the request, result and register channels of the interpolator,
// keeps its own copy of the table and registers, predicts each query's
// distance and status, and compares them with the result beats in order.
// ----------------------------------------------------------------------------
`default_nettype none
module ltint_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	ltint_req_if      req,
	ltint_rsp_if      rsp,
	ltint_cfg_if      cfg,
	output int        errors,
	output int        outstanding,
	output int        answered,
	output int        queries,
	output int        loads
);
	import ltint_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam longint SAT_Q24 = 64'sd2147483647;
	localparam longint DIST_MAX = 64'sd4294967295;

	typedef struct packed {
		logic [31:0] distance;
		logic [1:0]  status;
	} lookup_t;

	logic signed [31:0] key_mem [DEPTH];
	logic [31:0]        val_mem [DEPTH];
	logic [1:0]         order_reg;
	logic [11:0]        count_reg;
	lookup_t            pending_q [$];

	// saturate a magnitude to Q8.24 range and apply the sign
	function automatic longint signed_sat(longint unsigned mag, bit neg);
		longint m;
		m = (mag > SAT_Q24) ? SAT_Q24 : longint'(mag);
		return neg ? -m : m;
	endfunction

	// num / den in Q8.24, round half away from zero
	function automatic longint q24_div(longint num, longint den);
		longint unsigned un, ud;
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		return signed_sat(((un << 24) + ud / 2) / ud, (num < 0) != (den < 0));
	endfunction

	// Q8.24 product, round half away from zero
	function automatic longint q24_mul(longint a, longint b);
		longint unsigned ua, ub;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		return signed_sat((ua * ub + 64'd8388608) >> 24, (a < 0) != (b < 0));
	endfunction

	function automatic lookup_t interpolate(logic signed [31:0] x);
		lookup_t res;
		int n, i, j, k, m, start;
		bit distinct;
		longint w, f, v, sum_h, sum_l, r;
		distinct = 1;
		sum_h = 0;
		sum_l = 0;
		n = count_reg;
		if (n < 2) n = 2;
		if (n > DEPTH) n = DEPTH;
		// past the end of the table
		if (x >= key_mem[n-1]) begin
			res.distance = val_mem[n-1];
			res.status = STAT_ABOVE;
			return res;
		end
		res.status = (x < key_mem[0]) ? STAT_BELOW : STAT_INSIDE;
		for (j = 1; j < n - 1; j++)
			if (x < key_mem[j]) break;
		i = j - 1;
		// stencil selection with cubic fallback and low-end shift
		m = (order_reg == 0) ? 1 : order_reg;
		if (m == 3 && i + 2 >= n) m = 2;
		if (m > n - 1) m = n - 1;
		start = (m == 1 || i == 0) ? i : i - 1;
		for (k = start; k <= start + m; k++)
			for (j = k + 1; j <= start + m; j++)
				if (key_mem[k] == key_mem[j]) distinct = 0;
		if (!distinct) begin
			res.distance = val_mem[i];
			return res;
		end
		for (k = start; k <= start + m; k++) begin
			w = 0;
			v = val_mem[k];
			for (j = start; j <= start + m; j++) begin
				if (j == k) continue;
				f = q24_div(longint'(x) - key_mem[j], longint'(key_mem[k]) - key_mem[j]);
				w = (w == 0 && j == ((k == start) ? start + 1 : start)) ? f : q24_mul(w, f);
			end
			sum_h += (v >> 16) * w;
			sum_l += (v & 64'hFFFF) * w;
		end
		sum_l += 64'sd8388608;
		r = (sum_h + (sum_l >>> 16)) >>> 8;
		if (r < 0) r = 0;
		if (r > DIST_MAX) r = DIST_MAX;
		res.distance = r[31:0];
		return res;
	endfunction

	assign outstanding = pending_q.size();

	initial begin
		errors = 0;
		answered = 0;
		queries = 0;
		loads = 0;
		foreach (key_mem[e]) begin
			key_mem[e] = '0;
			val_mem[e] = '0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			order_reg <= 2'd1;
			count_reg <= 12'd2;
		end else begin
			// register write beats
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_INTERP_ORDER)
					order_reg <= cfg.data[1:0];
				else if (cfg.index == REG_ENTRIES_IN_USE)
					count_reg <= cfg.data;
			end
			// request beats: load or predict
			if (req.valid && req.ready) begin
				if (req.command == CMD_LOAD) begin
					key_mem[req.entry_index] = req.log_key;
					val_mem[req.entry_index] = req.entry_value;
					loads++;
				end else begin
					pending_q.push_back(interpolate(req.log_key));
					queries++;
				end
			end
			// result beats
			if (rsp.valid && rsp.ready) begin
				if (pending_q.size() == 0) begin
					$error("result beat with no query waiting: distance %h status %0d",
						rsp.distance, rsp.status);
					errors++;
				end else begin
					want = pending_q.pop_front();
					if (rsp.distance !== want.distance) begin
						$error("distance: expected %h, got %h", want.distance, rsp.distance);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errors++;
					end
				end
				answered++;
			end
		end
	end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Lagrange table interpolator: register settings per phase,
// ascending tables loaded entry by entry, and queries inside, below and past
// the table, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	localparam int DEPTH = ltint_pkg::TABLE_DEPTH_DEF;
	localparam longint KEY_MIN = -64'sd2147483648;
	localparam longint KEY_MAX = 64'sd2147483647;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, outstanding, answered, queries, loads;
	int   items_sent = 0;
	int   burst_left = 0;
	bit   stim_done = 0;
	bit   held_off = 0;
	longint tkey [DEPTH];
	longint lo_key, hi_key;

	ltint_req_if req_ch ();
	ltint_rsp_if rsp_ch ();
	ltint_cfg_if cfg_ch ();

	lagrange_table_interpolator uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
	);

	ltint_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
		.errors(errors), .outstanding(outstanding), .answered(answered),
		.queries(queries), .loads(loads)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.command = ltint_pkg::CMD_QUERY;
		req_ch.entry_index = '0;
		req_ch.log_key = '0;
		req_ch.entry_value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = ltint_pkg::REG_INTERP_ORDER;
		cfg_ch.data = '0;
	end

	// one request beat, with bursts and random gaps
	task automatic send_beat(logic cmd, logic [10:0] idx, longint key, logic [31:0] val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.entry_index <= idx;
		req_ch.log_key <= key[31:0];
		req_ch.entry_value <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic load_entry(int idx, longint key, logic [31:0] val);
		tkey[idx] = key;
		send_beat(ltint_pkg::CMD_LOAD, idx[10:0], key, val);
	endtask

	// registers only change once the block has gone quiet
	task automatic write_reg(logic [ltint_pkg::CFG_INDEX_W-1:0] idx,
		logic [ltint_pkg::CFG_DATA_W-1:0] data);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_value(int mode, longint base);
		if ($urandom_range(0, 15) == 0) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
		if (mode == 0) return $urandom;
		return 32'(base + $urandom_range(0, 32'h0010_0000));
	endfunction

	// ascending table of n entries between lo_key and hi_key
	task automatic fill_table(int n);
		int span_mode, val_mode, s;
		longint base, k;
		span_mode = $urandom_range(0, 3);
		val_mode = $urandom_range(0, 2);
		base = $urandom_range(0, 32'h7FFF_0000);
		if (span_mode == 0) begin
			lo_key = KEY_MIN;
			hi_key = KEY_MAX;
		end else if (span_mode == 1) begin
			lo_key = longint'($signed($urandom)) / 2;
			hi_key = lo_key + longint'(n) * $urandom_range(1, 32'h0100_0000);
			if (hi_key > KEY_MAX) hi_key = KEY_MAX;
		end else begin
			lo_key = longint'($signed($urandom)) / 4;
			hi_key = lo_key + longint'(n) * $urandom_range(1, 4096);
		end
		for (int e = 0; e < n; e++) begin
			k = lo_key + ((hi_key - lo_key) * e) / (n - 1);
			if (e > 0 && $urandom_range(0, 15) == 0) k = tkey[e-1];
			load_entry(e, k, rand_value(val_mode, base));
		end
		// stray loads past the entries in use
		if (n < DEPTH)
			repeat ($urandom_range(0, 3)) begin
				s = $urandom_range(n, DEPTH - 1);
				load_entry(s, longint'($signed($urandom)), $urandom);
			end
	endtask

	task automatic query_random(int n);
		longint x;
		int pick;
		pick = $urandom_range(0, 11);
		case (pick)
			0: x = tkey[$urandom_range(0, n - 1)];
			1: x = (lo_key > KEY_MIN) ? lo_key - 1 - $urandom_range(0, 32'h0100_0000) : lo_key;
			2: x = hi_key + $urandom_range(0, 32'h0100_0000);
			3: x = ($urandom_range(0, 1) != 0) ? KEY_MIN : KEY_MAX;
			default: x = lo_key + (longint'({$urandom}) % (hi_key - lo_key + 1));
		endcase
		if (x < KEY_MIN) x = KEY_MIN;
		if (x > KEY_MAX) x = KEY_MAX;
		send_beat(ltint_pkg::CMD_QUERY, 11'($urandom), x, $urandom);
	endtask

	// reset, stimulus and verdict
	initial begin
		int n, phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small cubic table with extreme keys and values
		write_reg(ltint_pkg::REG_INTERP_ORDER, 12'd3);
		write_reg(ltint_pkg::REG_ENTRIES_IN_USE, 12'd5);
		load_entry(0, KEY_MIN, 32'h0);
		load_entry(1, -64'sd16777216, 32'hFFFF_FFFF);
		load_entry(2, 0, 32'h0001_0000);
		load_entry(3, 64'sd16777216, 32'h0005_0000);
		load_entry(4, 64'sd33554432, 32'h0002_0000);
		send_beat(ltint_pkg::CMD_QUERY, 11'h7FF, KEY_MIN, 32'hFFFF_FFFF);
		send_beat(ltint_pkg::CMD_QUERY, '0, KEY_MAX, '0);
		send_beat(ltint_pkg::CMD_QUERY, '0, 64'sd33554432, '0);
		send_beat(ltint_pkg::CMD_QUERY, '0, 64'sd8388608, '0);
		send_beat(ltint_pkg::CMD_QUERY, '0, -64'sd8388608, '0);
		send_beat(ltint_pkg::CMD_QUERY, '0, 64'sd25165824, '0);
		// below the first key, then a repeated key in the stencil
		load_entry(0, -64'sd33554432, 32'h0003_0000);
		send_beat(ltint_pkg::CMD_QUERY, '0, KEY_MIN, '0);
		load_entry(1, 0, 32'h0004_0000);
		send_beat(ltint_pkg::CMD_QUERY, '0, 64'sd1000, '0);
		send_beat(ltint_pkg::CMD_QUERY, '0, -64'sd1000, '0);
		write_reg(ltint_pkg::REG_INTERP_ORDER, 12'd0);
		send_beat(ltint_pkg::CMD_QUERY, '0, 64'sd20000000, '0);

		// full-depth entry count: a short table topped by maximum keys, so the
		// scan always stops inside the loaded part; then out-of-range counts
		write_reg(ltint_pkg::REG_INTERP_ORDER, 12'd3);
		write_reg(ltint_pkg::REG_ENTRIES_IN_USE, 12'd2048);
		fill_table(160);
		load_entry(160, KEY_MAX, $urandom);
		load_entry(161, KEY_MAX, $urandom);
		load_entry(DEPTH - 1, KEY_MAX, $urandom);
		repeat (8) query_random(160);
		write_reg(ltint_pkg::REG_ENTRIES_IN_USE, 12'd4095);
		repeat (4) query_random(160);
		write_reg(ltint_pkg::REG_ENTRIES_IN_USE, 12'd0);
		repeat (6) query_random(2);

		// random phases, mostly small tables
		phase = 0;
		while (items_sent < 1600) begin
			n = ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(3, 40);
			if (phase % 25 == 24) n = $urandom_range(100, 300);
			write_reg(ltint_pkg::REG_INTERP_ORDER, 12'($urandom_range(0, 3)));
			write_reg(ltint_pkg::REG_ENTRIES_IN_USE, 12'(n));
			fill_table(n);
			repeat ((n > 100) ? 6 : $urandom_range(10, 40)) query_random(n);
			phase++;
		end
		req_ch.valid <= 1'b0;
		stim_done = 1;

		while (outstanding != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Run: %0d table loads, %0d queries over %0d phases; %0d results checked.",
			loads, queries, phase, answered);
		$display("Orders 0..3, entry counts 0 to 4095, keys and values at both extremes.");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// result side: stall patterns plus one long hold-off
	initial begin
		int mode, len;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(20, 400);
			if (!held_off && !stim_done && answered >= 150) begin
				held_off = 1;
				rsp_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end
			repeat (len) begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		#40000000;
		$display("Timeout: %0d queries sent, %0d results seen.", queries, answered);
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/ltint_pkg.sv
hdl/ltint_if.sv
hdl/ltint_tables.sv
hdl/ltint_div.sv
hdl/lagrange_table_interpolator.sv
tb/ltint_checker.sv
tb/tb.sv
